[hdl/mm2_pkg.sv]
package mm2_pkg;

	localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
	localparam int          MIX_SHIFT   = 24;
	localparam int          FIN_SHIFT_A = 13;
	localparam int          FIN_SHIFT_B = 15;
	localparam logic [31:0] SEED_RESET  = 32'h0000_00fa;

	typedef logic [1:0] op_t;

	// shared unit operations
	localparam op_t OP_KMUL  = 2'd0;	// a*M
	localparam op_t OP_KMIX  = 2'd1;	// (a ^ a>>24)*M
	localparam op_t OP_HMIX  = 2'd2;	// (a*M) ^ b
	localparam op_t OP_FMIX  = 2'd3;	// (a ^ a>>13)*M

	localparam int FULL_BYTES = 4;

endpackage

[hdl/mm2_unit.sv]
module mm2_unit
	import mm2_pkg::*;
(
	input  op_t         op,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);

	logic [31:0] operand;
	logic [31:0] product;

	always_comb begin
		case (op)
			OP_KMUL: operand = a;
			OP_KMIX: operand = a ^ (a >> MIX_SHIFT);
			OP_HMIX: operand = a;
			OP_FMIX: operand = a ^ (a >> FIN_SHIFT_A);
			default: operand = a;
		endcase
	end

	assign product = operand * MIX_MUL;
	assign y       = (op == OP_HMIX) ? (product ^ b) : product;

endmodule

[hdl/murmur2_hash_32.sv]
// channel | valid    | stall     | payload
// in      | in_valid | in_stall  | data_word, bytes_valid, first_item, last_item, message_length
// out     | out_valid| out_stall | hash_value
// cfg     | cfg_we   | -         | cfg_wdata (seed)
//
// Full word: the request, then three passes through the one shared multiplier.
// Tail word: the request and one pass; empty word: the request only. Last word: then the avalanche.
// Reset (arst_n low) clears the running hash and out_valid, seed to 0xfa, and the sequencer.
// A finished hash waits in the output register; a new request is taken meanwhile,
// and only the next avalanche waits for out_stall to drop.
module murmur2_hash_32
	import mm2_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  bytes_valid,
	input  logic        first_item,
	input  logic        last_item,
	input  logic [31:0] message_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] hash_value
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_K1   = 3'd1;
	localparam logic [2:0] ST_K2   = 3'd2;
	localparam logic [2:0] ST_H    = 3'd3;
	localparam logic [2:0] ST_F1   = 3'd4;
	localparam logic [2:0] ST_F2   = 3'd5;

	logic [2:0]  state_q;
	logic [31:0] seed_q;
	logic [31:0] h_q;
	logic [31:0] k_q;
	logic        last_q;
	logic [31:0] hash_q;
	logic        out_valid_q;

	logic        accept;
	logic [31:0] h_start;
	logic [31:0] tail_mask;
	op_t         op;
	logic [31:0] unit_a;
	logic [31:0] unit_y;
	logic        out_free;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign h_start  = first_item ? (seed_q ^ message_length) : h_q;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		case (bytes_valid[1:0])
			2'd1:    tail_mask = 32'h0000_00ff;
			2'd2:    tail_mask = 32'h0000_ffff;
			2'd3:    tail_mask = 32'h00ff_ffff;
			default: tail_mask = 32'h0000_0000;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_K1:   begin op = OP_KMUL; unit_a = k_q; end
			ST_K2:   begin op = OP_KMIX; unit_a = k_q; end
			ST_H:    begin op = OP_HMIX; unit_a = h_q; end
			ST_F1:   begin op = OP_FMIX; unit_a = h_q; end
			default: begin op = OP_KMUL; unit_a = k_q; end
		endcase
	end

	mm2_unit u_unit (
		.op (op),
		.a  (unit_a),
		.b  (k_q),
		.y  (unit_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_q      <= SEED_RESET;
			h_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if ((state_q == ST_F2) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (bytes_valid[2]) begin
							h_q     <= h_start;
							state_q <= ST_K1;
						end else if (bytes_valid[1:0] != 2'd0) begin
							h_q     <= h_start ^ (data_word & tail_mask);
							state_q <= ST_H;
						end else begin
							h_q     <= h_start;
							state_q <= last_item ? ST_F1 : ST_IDLE;
						end
					end
				end
				ST_K1:   state_q <= ST_K2;
				ST_K2:   state_q <= ST_H;
				ST_H: begin
					h_q     <= unit_y;
					state_q <= last_q ? ST_F1 : ST_IDLE;
				end
				ST_F1:   state_q <= ST_F2;
				ST_F2: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					k_q    <= bytes_valid[2] ? data_word : '0;
					last_q <= last_item;
				end
			end
			ST_K1, ST_K2, ST_F1: k_q <= unit_y;
			ST_F2: begin
				if (out_free) begin
					hash_q <= k_q ^ (k_q >> FIN_SHIFT_B);
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

endmodule

[hdl/mm2_chk.sv]
module mm2_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last_item,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] hash_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hash_value))
		else $error("stalled result changed");

	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a busy sequencer");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !last_item |=> !$rose(out_valid))
		else $error("result right after a non-last request");

endmodule

bind murmur2_hash_32 mm2_chk u_mm2_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.last_item  (last_item),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.hash_value (hash_value)
);

[verif/murmur2_hash_32_test.sv]
`timescale 1ns / 1ps

module murmur2_hash_32_test
	import mm2_pkg::*;
();

	localparam int IDLE_LIMIT      = 2000;
	localparam int SETTLE_CYCLES   = 16;
	localparam int RANDOM_PER_SEED = 180;
	localparam int REPORT_MAX      = 10;

	class hash_scoreboard;
		logic [31:0] seed_reg;
		logic [31:0] run_hash;
		logic [31:0] expected_hashes[$];
		int          mismatches;
		int          hashes_checked;

		function new();
			seed_reg       = SEED_RESET;
			run_hash       = '0;
			mismatches     = 0;
			hashes_checked = 0;
		endfunction

		function void set_seed(logic [31:0] v);
			seed_reg = v;
		endfunction

		// one request through the hash datapath; a last word queues the finished hash
		function void note_request(logic [31:0] w, logic [2:0] nb, logic f, logic l,
				logic [31:0] len);
			logic [31:0] h;
			logic [31:0] k;
			logic [31:0] mask;
			h = f ? (seed_reg ^ len) : run_hash;
			if (nb >= FULL_BYTES) begin
				k = w * MIX_MUL;
				k = k ^ (k >> MIX_SHIFT);
				k = k * MIX_MUL;
				h = h * MIX_MUL;
				h = h ^ k;
			end else if (nb != 0) begin
				mask = (32'h1 << (8 * nb)) - 32'h1;
				h = h ^ (w & mask);
				h = h * MIX_MUL;
			end
			run_hash = h;
			if (l) begin
				h = h ^ (h >> FIN_SHIFT_A);
				h = h * MIX_MUL;
				h = h ^ (h >> FIN_SHIFT_B);
				expected_hashes.push_back(h);
			end
		endfunction

		function void check_hash(logic [31:0] got);
			logic [31:0] want;
			if (expected_hashes.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: hash %h arrived with none expected", $realtime, got);
				return;
			end
			want = expected_hashes.pop_front();
			hashes_checked++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: hash_value expected %h got %h", $realtime, want, got);
			end
		endfunction

		function int pending();
			return expected_hashes.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] data_word;
	logic [2:0]  bytes_valid;
	logic        first_item;
	logic        last_item;
	logic [31:0] message_length;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] hash_value;

	hash_scoreboard sb;
	int             sent_items;
	int             seed_settings;
	int             calm_in;
	int             calm_out;
	int             idle_cycles;

	murmur2_hash_32 u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_word      (data_word),
		.bytes_valid    (bytes_valid),
		.first_item     (first_item),
		.last_item      (last_item),
		.message_length (message_length),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hash_value     (hash_value)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mostly no gap, some short, a few long, with occasional calm stretches
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 40);
	endfunction

	task automatic send_request(input logic [31:0] w, input logic [2:0] nb, input logic f,
			input logic l, input logic [31:0] len);
		int gap;
		gap = pick_gap(calm_in);
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid       = 1'b1;
		data_word      = w;
		bytes_valid    = nb;
		first_item     = f;
		last_item      = l;
		message_length = len;
		do @(posedge clk); while (in_stall);
		sb.note_request(w, nb, f, l, len);
		sent_items++;
	endtask

	// drop_first: continue from the running hash; early_tail: short word mid-message
	task automatic send_message(input int nbytes, input bit honest, input bit drop_first,
			input bit early_tail);
		int          nfull;
		int          tail;
		int          i;
		logic [31:0] len;
		logic [2:0]  nb;
		nfull = nbytes / 4;
		tail  = nbytes % 4;
		len   = honest ? nbytes : $urandom;
		if (nfull == 0 && tail == 0) begin
			send_request($urandom, 3'd0, !drop_first, 1'b1, len);
			return;
		end
		for (i = 0; i < nfull; i++) begin
			nb = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'(FULL_BYTES);
			send_request($urandom, nb, (i == 0) && !drop_first,
				(i == nfull - 1) && (tail == 0), len);
			if (early_tail && i == 0)
				send_request($urandom, 3'($urandom_range(1, 3)), 1'b0, 1'b0, $urandom);
		end
		if (tail != 0)
			send_request($urandom, 3'(tail), (nfull == 0) && !drop_first, 1'b1, len);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] v);
		settle();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(posedge clk);
		sb.set_seed(v);
		seed_settings++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic directed_requests();
		send_request(32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'd0);
		send_request(32'hffff_ffff, 3'd1, 1'b1, 1'b1, 32'd1);
		send_request(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 32'hffff_ffff);
		send_request(32'h0000_0000, 3'd4, 1'b1, 1'b1, 32'd4);
		send_request(32'hffff_ffff, 3'd7, 1'b1, 1'b1, 32'd0);
		send_request(32'h0000_0000, 3'd4, 1'b1, 1'b0, 32'd6);
		send_request(32'hffff_ffff, 3'd2, 1'b0, 1'b1, 32'd0);
		// short word ahead of a full one, then an empty closing word
		send_request(32'h1234_5678, 3'd2, 1'b1, 1'b0, 32'd6);
		send_request(32'hffff_ffff, 3'd4, 1'b0, 1'b0, 32'd0);
		send_request(32'h8000_0001, 3'd0, 1'b0, 1'b1, 32'd0);
		// carries on from the held pre-avalanche hash
		send_request(32'hdead_beef, 3'd4, 1'b0, 1'b0, 32'hffff_ffff);
		send_request(32'h0000_00ff, 3'd1, 1'b0, 1'b1, 32'd0);
		send_request(32'h0000_0000, 3'd0, 1'b0, 1'b1, 32'd0);
		send_request(32'hffff_ffff, 3'd5, 1'b1, 1'b0, 32'd11);
		send_request(32'h0000_0000, 3'd6, 1'b0, 1'b0, 32'd0);
		send_request(32'hffff_ffff, 3'd3, 1'b0, 1'b1, 32'd0);
		// restart mid-message
		send_request(32'hffff_ffff, 3'd4, 1'b1, 1'b0, 32'd100);
		send_request(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 32'd4);
	endtask

	task automatic random_requests(input int count);
		int stop_at;
		int r;
		int nbytes;
		stop_at = sent_items + count;
		while (sent_items < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 90)
				nbytes = $urandom_range(0, 24);
			else if (r < 98)
				nbytes = $urandom_range(25, 64);
			else
				nbytes = $urandom_range(65, 200);
			r = $urandom_range(0, 99);
			if (r < 80)
				send_message(nbytes, $urandom_range(0, 9) != 0, 1'b0, 1'b0);
			else if (r < 90)
				send_message(nbytes, 1'b1, $urandom_range(0, 1), $urandom_range(0, 1));
			else
				send_request($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), $urandom);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_hash(hash_value);
	end

	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = pick_gap(calm_out);
			@(negedge clk);
			if (n == 0) begin
				out_stall = 1'b0;
			end else begin
				out_stall = 1'b1;
				repeat (n - 1) @(negedge clk);
				@(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no request moved for %0d cycles", $realtime, IDLE_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		sb             = new();
		sent_items     = 0;
		seed_settings  = 1;
		calm_in        = 0;
		calm_out       = 0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		in_valid       = 1'b0;
		data_word      = '0;
		bytes_valid    = '0;
		first_item     = 1'b0;
		last_item      = 1'b0;
		message_length = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_requests();
		random_requests(RANDOM_PER_SEED);
		write_seed(32'h0000_0000);
		directed_requests();
		random_requests(RANDOM_PER_SEED);
		write_seed(32'hffff_ffff);
		random_requests(RANDOM_PER_SEED);
		write_seed($urandom);
		random_requests(RANDOM_PER_SEED);
		write_seed(32'h8000_0001);
		random_requests(RANDOM_PER_SEED);
		write_seed($urandom);
		random_requests(RANDOM_PER_SEED);
		settle();

		$display("%0d requests over %0d seed values, %0d hashes compared",
			sent_items, seed_settings, sb.hashes_checked);
		$display("%0d mismatches, %0d hashes never arrived", sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
hdl/mm2_pkg.sv
hdl/mm2_unit.sv
hdl/murmur2_hash_32.sv
hdl/mm2_chk.sv
verif/murmur2_hash_32_test.sv
